@@ design/call_stack_latency_accounting_top_assert.svh @@
// assertion macros for the call stack latency accounting checker
`ifndef CALL_STACK_LATENCY_ACCOUNTING_TOP_ASSERT_SVH
`define CALL_STACK_LATENCY_ACCOUNTING_TOP_ASSERT_SVH

// checked only out of reset
`define CSLA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CSLA_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/csla_pkg.sv @@
// ----------------------------------------------------------------------------
// csla_pkg
// types, codes and helpers shared by the call stack latency accounting block
// ----------------------------------------------------------------------------
package csla_pkg;

	localparam logic [2:0] CMD_ENTER     = 3'd0;
	localparam logic [2:0] CMD_ENTER_ARG = 3'd1;
	localparam logic [2:0] CMD_EXIT      = 3'd2;
	localparam logic [2:0] CMD_TAIL_EXIT = 3'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OLD      = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_NO_MATCH = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [1:0] REG_RECURSIVE_ONLY  = 2'd0;
	localparam logic [1:0] REG_DEDUCE_SIBLINGS = 2'd1;

	localparam logic [5:0] CNT_MAX       = 6'd63;
	localparam logic [5:0] CNT_RECURSIVE = 6'd2;

	typedef enum logic [1:0] {
		K_OLD,
		K_ENTER,
		K_EXIT,
		K_OTHER
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  tid;
		logic [9:0]  fid;
		logic [63:0] ts;
	} item_t;

	typedef struct packed {
		logic rec_only;
		logic deduce;
	} cfg_t;

	// depth counter word: mark on top, count below
	typedef struct packed {
		logic       mark;
		logic [5:0] cnt;
	} rec_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_UP,
		S_SINGLE,
		S_SEARCH,
		S_E_RD,
		S_E_FR,
		S_E_OUT,
		S_D_RD,
		S_D_FR,
		S_D_WR
	} bstate_t;

	// remainder by a constant through shifted compare and subtract
	function automatic logic [2:0] mod_tid(logic [2:0] v, int unsigned m);
		logic [31:0] r;
		r = 32'(v);
		for (int k = 2; k >= 0; k--) begin
			if (r >= (32'(m) << k))
				r = r - (32'(m) << k);
		end
		return r[2:0];
	endfunction

	function automatic logic [9:0] mod_fid(logic [9:0] v, int unsigned m);
		logic [31:0] r;
		r = 32'(v);
		for (int k = 9; k >= 0; k--) begin
			if (r >= (32'(m) << k))
				r = r - (32'(m) << k);
		end
		return r[9:0];
	endfunction

	function automatic rec_t rec_up(rec_t w);
		rec_t n;
		n.cnt  = (w.cnt < CNT_MAX) ? w.cnt + 6'd1 : w.cnt;
		n.mark = w.mark | (n.cnt == CNT_RECURSIVE);
		return n;
	endfunction

	function automatic rec_t rec_down(rec_t w);
		rec_t n;
		n.cnt  = (w.cnt != 6'd0) ? w.cnt - 6'd1 : w.cnt;
		n.mark = w.mark & (n.cnt != 6'd0);
		return n;
	endfunction

endpackage

@@ design/csla_front.sv @@
// ----------------------------------------------------------------------------
// csla_front
// accepts trace records, latches the first timestamp and classifies them
// ----------------------------------------------------------------------------
module csla_front import csla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [2:0]  tid,
	input  logic [9:0]  fid,
	input  logic [63:0] ts,
	output logic        push,
	output item_t       push_item,
	input  logic        q_full
);

	logic [63:0] first_stamp_q;
	logic [63:0] fs_eff;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign fs_eff   = (first_stamp_q == 64'd0) ? ts : first_stamp_q;

	always_comb begin
		push_item.tid = tid;
		push_item.fid = fid;
		push_item.ts  = ts;
		priority if (ts < fs_eff)
			push_item.kind = K_OLD;
		else if (cmd == CMD_ENTER || cmd == CMD_ENTER_ARG)
			push_item.kind = K_ENTER;
		else if (cmd == CMD_EXIT || cmd == CMD_TAIL_EXIT)
			push_item.kind = K_EXIT;
		else
			push_item.kind = K_OTHER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_stamp_q <= 64'd0;
		end else if (push && first_stamp_q == 64'd0) begin
			first_stamp_q <= ts;
		end
	end

endmodule

@@ design/csla_queue.sv @@
// ----------------------------------------------------------------------------
// csla_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module csla_queue import csla_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t head
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ design/csla_back.sv @@
// ----------------------------------------------------------------------------
// csla_back
// per-thread call stacks, depth counters and the result sequencer
// ----------------------------------------------------------------------------
module csla_back import csla_pkg::*; #(
	parameter int unsigned THREADS     = 8,
	parameter int unsigned STACK_DEPTH = 32,
	parameter int unsigned FUNC_IDS    = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_status,
	output logic        out_lat_valid,
	output logic [9:0]  out_func,
	output logic [63:0] out_latency,
	output logic        out_last
);

	localparam int unsigned TW   = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int unsigned FW   = (FUNC_IDS > 1) ? $clog2(FUNC_IDS) : 1;
	localparam int unsigned SW   = $clog2(STACK_DEPTH);
	localparam int unsigned PW   = $clog2(STACK_DEPTH + 1);
	localparam int unsigned FRN  = THREADS * STACK_DEPTH;
	localparam int unsigned FRW  = $clog2(FRN);
	localparam int unsigned RN   = THREADS * FUNC_IDS;
	localparam int unsigned RW   = $clog2(RN);

	typedef struct packed {
		logic [FW-1:0] func;
		logic [63:0]   stamp;
	} frame_t;

	bstate_t state_q, state_d;

	frame_t         fr_mem [FRN];
	frame_t         fr_rd_q;
	logic           fr_we;
	logic [FRW-1:0] fr_wa, fr_ra;
	frame_t         fr_wd;

	rec_t           rec_mem [RN];
	rec_t           rec_rd_q;
	logic [RW-1:0]  rec_addr_q, rec_ra, rec_wa;
	logic           rec_we;
	rec_t           rec_wd;
	logic [RW-1:0]  clr_q;

	logic [PW-1:0]  fill_q [THREADS];

	logic [TW-1:0]  t_q, d_t;
	logic [FW-1:0]  f_q, d_f;
	logic [PW-1:0]  d_fill;
	logic [63:0]    ts_q;
	logic [2:0]     st_q;
	logic [SW-1:0]  j_q, start_q, top_q;
	logic [9:0]     fn_q;
	logic [63:0]    diff_q;
	logic           match, counted, out_load;

	logic [2:0]     o_status_q;
	logic           o_lv_q, o_last_q, o_valid_q;
	logic [9:0]     o_func_q;
	logic [63:0]    o_lat_q;

	function automatic logic [FRW-1:0] fr_idx(logic [TW-1:0] t, logic [SW-1:0] j);
		return FRW'(t) * FRW'(STACK_DEPTH) + FRW'(j);
	endfunction

	function automatic logic [RW-1:0] rec_idx(logic [TW-1:0] t, logic [FW-1:0] f);
		return RW'(t) * RW'(FUNC_IDS) + RW'(f);
	endfunction

	assign d_t      = TW'(mod_tid(q_head.tid, THREADS));
	assign d_f      = FW'(mod_fid(q_head.fid, FUNC_IDS));
	assign d_fill   = fill_q[d_t];
	assign match    = (fr_rd_q.func == f_q);
	assign counted  = !cfg.rec_only || rec_rd_q.mark;
	assign out_load = !o_valid_q || out_ready;

	assign out_valid     = o_valid_q;
	assign out_status    = o_status_q;
	assign out_lat_valid = o_lv_q;
	assign out_func      = o_func_q;
	assign out_latency   = o_lat_q;
	assign out_last      = o_last_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:
				if (clr_q == RW'(RN - 1))
					state_d = S_IDLE;
			S_IDLE:
				if (q_valid) begin
					unique case (q_head.kind)
						K_ENTER:
							if (d_fill == PW'(STACK_DEPTH) || !cfg.rec_only)
								state_d = S_SINGLE;
							else
								state_d = S_UP;
						K_EXIT:
							state_d = (d_fill == PW'(0)) ? S_SINGLE : S_SEARCH;
						default:
							state_d = S_SINGLE;
					endcase
				end
			S_UP:
				state_d = S_SINGLE;
			S_SINGLE:
				if (out_load)
					state_d = S_IDLE;
			S_SEARCH:
				priority if (match)
					state_d = S_E_RD;
				else if (!cfg.deduce || j_q == SW'(0))
					state_d = S_SINGLE;
			S_E_RD:
				state_d = S_E_FR;
			S_E_FR:
				state_d = S_E_OUT;
			S_E_OUT:
				if (out_load) begin
					priority if (j_q != top_q)
						state_d = S_E_RD;
					else if (cfg.rec_only)
						state_d = S_D_RD;
					else
						state_d = S_IDLE;
				end
			S_D_RD:
				state_d = S_D_FR;
			S_D_FR:
				state_d = S_D_WR;
			S_D_WR:
				state_d = (j_q == start_q) ? S_IDLE : S_D_RD;
			default:
				state_d = S_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		fr_we  = 1'b0;
		fr_wa  = fr_idx(d_t, SW'(d_fill));
		fr_wd  = '{func: d_f, stamp: q_head.ts};
		fr_ra  = fr_idx(t_q, j_q);
		rec_ra = rec_addr_q;
		rec_we = 1'b0;
		rec_wa = rec_addr_q;
		rec_wd = rec_up(rec_rd_q);
		unique case (state_q)
			S_CLEAR: begin
				rec_we = 1'b1;
				rec_wa = clr_q;
				rec_wd = '0;
			end
			S_IDLE: begin
				pop    = q_valid;
				fr_we  = q_valid && q_head.kind == K_ENTER && d_fill != PW'(STACK_DEPTH);
				fr_ra  = fr_idx(d_t, SW'(d_fill - PW'(1)));
				rec_ra = rec_idx(d_t, d_f);
			end
			S_UP:
				rec_we = 1'b1;
			S_SEARCH:
				fr_ra = fr_idx(t_q, j_q - SW'(1));
			S_E_FR:
				rec_ra = rec_idx(t_q, fr_rd_q.func);
			S_D_FR:
				rec_ra = rec_idx(t_q, fr_rd_q.func);
			S_D_WR: begin
				rec_we = 1'b1;
				rec_wd = rec_down(rec_rd_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fr_we)
			fr_mem[fr_wa] <= fr_wd;
		fr_rd_q <= fr_mem[fr_ra];
	end

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_mem[rec_wa] <= rec_wd;
		rec_rd_q   <= rec_mem[rec_ra];
		rec_addr_q <= rec_ra;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE:
				if (q_valid) begin
					t_q   <= d_t;
					f_q   <= d_f;
					ts_q  <= q_head.ts;
					top_q <= SW'(d_fill - PW'(1));
					j_q   <= SW'(d_fill - PW'(1));
					unique case (q_head.kind)
						K_OLD:   st_q <= ST_OLD;
						K_ENTER: st_q <= (d_fill == PW'(STACK_DEPTH)) ? ST_FULL : ST_OK;
						K_EXIT:  st_q <= (d_fill == PW'(0)) ? ST_EMPTY : ST_NO_MATCH;
						default: st_q <= ST_OK;
					endcase
				end
			S_SEARCH:
				if (match)
					start_q <= j_q;
				else
					j_q <= j_q - SW'(1);
			S_E_FR: begin
				fn_q   <= 10'(fr_rd_q.func);
				diff_q <= (fr_rd_q.stamp > ts_q) ? fr_rd_q.stamp - ts_q
				                                 : ts_q - fr_rd_q.stamp;
			end
			S_E_OUT:
				if (out_load && j_q != top_q)
					j_q <= j_q + SW'(1);
			S_D_WR:
				j_q <= j_q - SW'(1);
			default: ;
		endcase
		if (out_load && state_q == S_SINGLE) begin
			o_status_q <= st_q;
			o_lv_q     <= 1'b0;
			o_func_q   <= 10'd0;
			o_lat_q    <= 64'd0;
			o_last_q   <= 1'b1;
		end else if (out_load && state_q == S_E_OUT) begin
			o_status_q <= ST_OK;
			o_lv_q     <= counted;
			o_func_q   <= fn_q;
			o_lat_q    <= counted ? diff_q : 64'd0;
			o_last_q   <= (j_q == top_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			o_valid_q <= 1'b0;
			for (int i = 0; i < THREADS; i++)
				fill_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + RW'(1);
			if ((state_q == S_SINGLE || state_q == S_E_OUT) && out_load)
				o_valid_q <= 1'b1;
			else if (out_ready)
				o_valid_q <= 1'b0;
			if (fr_we)
				fill_q[d_t] <= d_fill + PW'(1);
			if ((state_q == S_E_OUT && out_load && j_q == top_q && !cfg.rec_only)
			    || (state_q == S_D_WR && j_q == start_q))
				fill_q[t_q] <= PW'(start_q);
		end
	end

endmodule

@@ design/call_stack_latency_accounting_top.sv @@
// ----------------------------------------------------------------------------
// call_stack_latency_accounting_top
// per-thread call stack tracking with frame latency results
// ----------------------------------------------------------------------------
// After reset the depth counter store is swept clear, one entry a cycle,
// over all THREADS*FUNC_IDS entries (8192 by default); records queue up but
// none is carried out until then. An enter with recursive_only set onto a
// stack that is not full also steps its depth counter up before its result.
// An exit searches the stack from the top, one frame at a time; on a match
// it reads each popped frame and gives its result, and with recursive_only
// set then walks the depth counters of the popped frames back down. An exit
// that ends in an error gives its result when the search stops. The frame
// store and the depth counter store have a single read port each. A queue
// of two entries lets new records in while a result waits.
module call_stack_latency_accounting_top import csla_pkg::*; #(
	parameter int unsigned THREADS     = 8,
	parameter int unsigned STACK_DEPTH = 32,
	parameter int unsigned FUNC_IDS    = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // thread_id, func_id, timestamp, zero pad
	input  logic [2:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // latency_valid, frame_func, latency, zero pad
	output logic [2:0]  m_tuser,   // status
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);

	cfg_t        cfg_q;
	logic        push, q_full, pop, q_valid;
	item_t       push_item, q_head;
	logic        lv;
	logic [9:0]  func;
	logic [63:0] lat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_RECURSIVE_ONLY)
				cfg_q.rec_only <= cfg_data;
			if (cfg_index == REG_DEDUCE_SIBLINGS)
				cfg_q.deduce <= cfg_data;
		end
	end

	csla_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (s_tuser),
		.tid       (s_tdata[2:0]),
		.fid       (s_tdata[12:3]),
		.ts        (s_tdata[76:13]),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	csla_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	csla_back #(
		.THREADS     (THREADS),
		.STACK_DEPTH (STACK_DEPTH),
		.FUNC_IDS    (FUNC_IDS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_status    (m_tuser),
		.out_lat_valid (lv),
		.out_func      (func),
		.out_latency   (lat),
		.out_last      (m_tlast)
	);

	assign m_tdata = {5'd0, lat, func, lv};

endmodule

@@ design/csla_checker.sv @@
// ----------------------------------------------------------------------------
// csla_checker
// port-level checks on the call stack latency accounting block
// ----------------------------------------------------------------------------
`include "call_stack_latency_accounting_top_assert.svh"

module csla_checker import csla_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	`CSLA_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result item dropped or changed while stalled")
	`CSLA_CHECK(a_err_single, m_tvalid && m_tuser != ST_OK |-> m_tlast, "error result not marked last")
	`CSLA_CHECK(a_uncounted_zero, m_tvalid && !m_tdata[0] |-> m_tdata[74:11] == 64'd0, "uncounted result carries a latency")
	`CSLA_CHECK_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result item offered in reset")

endmodule

bind call_stack_latency_accounting_top csla_checker u_csla_checker (.*);
